// ===== design/wavhp_pkg.sv =====
// Shared constants, codes and types of the WAV header parser.
package wavhp_pkg;

  // Width of the saturating byte position counters.
  localparam int unsigned POS_BITS = 34;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Widths used by the chunk advance sum and the length clamp.
  localparam int unsigned CMP_BITS = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int unsigned SUM_BITS = CMP_BITS + 2;

  // Fixed positions and limits of the file layout.
  localparam logic [POS_BITS-1:0] MIN_SIZE    = POS_BITS'(44);
  localparam logic [POS_BITS-1:0] CHUNK_FIRST = POS_BITS'(12);
  localparam logic [POS_BITS-1:0] POS_RIFF_END = POS_BITS'(3);
  localparam logic [POS_BITS-1:0] POS_WAVE_END = POS_BITS'(11);
  localparam logic [POS_BITS-1:0] WIN_LAST    = POS_BITS'(23);

  // Byte offsets inside a chunk where a little-endian field completes.
  localparam logic [4:0] OFF_TAG      = 5'd3;
  localparam logic [4:0] OFF_LEN      = 5'd7;
  localparam logic [4:0] OFF_FORMAT   = 5'd9;
  localparam logic [4:0] OFF_CHANNELS = 5'd11;
  localparam logic [4:0] OFF_RATE     = 5'd15;
  localparam logic [4:0] OFF_BITS     = 5'd23;

  // Four-character tags as they look after four bytes are shifted in.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] FORMAT_PCM  = 16'd1;
  localparam logic [31:0] HDR_LEN     = 32'd8;

  // Configuration registers.
  localparam int unsigned RATE_W    = 18;
  localparam int unsigned CH_W      = 4;
  localparam int unsigned BITS_W    = 6;
  localparam int unsigned CFG_W     = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS     = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET     = 18'd48000;
  localparam logic [CH_W-1:0]   CHANNELS_RESET = 4'd1;
  localparam logic [BITS_W-1:0] BITS_RESET     = 6'd16;

  // Result status codes, in order of precedence.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BAD_TAG = 3'd2,
    ST_BAD_FMT = 3'd3,
    ST_NO_DATA = 3'd4
  } status_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CH_W-1:0]   channels;
    logic [BITS_W-1:0] bits;
  } cfg_t;

  // Parser state captured on the last byte of a file.
  typedef struct packed {
    logic [POS_BITS-1:0] size;
    logic                magic_ok;
    logic                fmt_ok;
    logic                data_found;
    logic [POS_BITS-1:0] data_start;
    logic [31:0]         data_length;
  } fin_t;

endpackage

// ===== design/wavhp_in_if.sv =====
// Byte stream channel into the WAV header parser.
interface wavhp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== design/wavhp_out_if.sv =====
// Result channel out of the WAV header parser.
interface wavhp_out_if import wavhp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [POS_BITS-1:0] data_offset;
  logic [30:0]         frame_count;

  modport source (output valid, output status, output data_offset, output frame_count,
                  input ready);
  modport sink (input valid, input status, input data_offset, input frame_count,
                output ready);
endinterface

// ===== design/wavhp_parse.sv =====
// Input register and per-byte chunk walker; captures the parse state on the last byte.
module wavhp_parse import wavhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  output logic       fin_valid_o,
  output fin_t       fin_o,
  input  logic       fin_ready_i
);

  // Input register.
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_last_q;

  // Parse state.
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] cs_q, cs_d;
  logic [31:0]         tag_q, tag_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         fs_q, fs_d;
  logic [15:0]         fmt_format_q, fmt_format_d;
  logic [15:0]         fmt_channels_q, fmt_channels_d;
  logic [31:0]         fmt_rate_q, fmt_rate_d;
  logic                magic_q, magic_d;
  logic                fmt_ok_q, fmt_ok_d;
  logic                dfound_q, dfound_d;
  logic [POS_BITS-1:0] dstart_q, dstart_d;
  logic [31:0]         dlen_q, dlen_d;

  logic                fin_valid_q;
  fin_t                fin_q, fin_d;

  logic                fin_free;
  logic                take;
  logic                parse_en;
  logic [31:0]         fs_new;
  logic [POS_BITS-1:0] diff;
  logic                in_win;
  logic [4:0]          off;
  logic                long_fmt;
  logic                do_adv;
  logic [31:0]         adv_len;
  logic [SUM_BITS-1:0] adv_sum;
  logic [POS_BITS-1:0] adv_cs;

  // The walker moves on a beat unless it is the last one and the capture stage is full.
  assign fin_free   = !fin_valid_q || fin_ready_i;
  assign take       = a_valid_q && (!a_last_q || fin_free);
  assign in_ready_o = !a_valid_q || take;

  // Chunk window decode and the next chunk start.
  assign parse_en = (pos_q != POS_MAX);
  assign fs_new   = {a_byte_q, fs_q[31:8]};
  assign diff     = pos_q - cs_q;
  assign in_win   = parse_en && (pos_q >= cs_q) && (diff <= WIN_LAST);
  assign off      = diff[4:0];
  assign long_fmt = (tag_q == TAG_FMT) && (len_q >= FMT_MIN_LEN);
  assign adv_len  = (off == OFF_LEN) ? fs_new : len_q;
  assign adv_sum  = SUM_BITS'(cs_q) + SUM_BITS'(HDR_LEN) + SUM_BITS'(adv_len)
                  + SUM_BITS'(adv_len[0]);
  assign adv_cs   = (adv_sum > SUM_BITS'(POS_MAX)) ? POS_MAX : adv_sum[POS_BITS-1:0];

  // Next parse state for the byte in the input register.
  always_comb begin
    fs_d           = fs_q;
    tag_d          = tag_q;
    len_d          = len_q;
    fmt_format_d   = fmt_format_q;
    fmt_channels_d = fmt_channels_q;
    fmt_rate_d     = fmt_rate_q;
    magic_d        = magic_q;
    fmt_ok_d       = fmt_ok_q;
    dfound_d       = dfound_q;
    dstart_d       = dstart_q;
    dlen_d         = dlen_q;
    do_adv         = 1'b0;

    if (parse_en) begin
      fs_d = fs_new;
      if (pos_q == POS_RIFF_END) begin
        magic_d = (fs_new == TAG_RIFF);
      end
      if (pos_q == POS_WAVE_END) begin
        magic_d = magic_q && (fs_new == TAG_WAVE);
      end
    end

    if (in_win) begin
      if (off == OFF_TAG) begin
        tag_d = fs_new;
      end else if (off == OFF_LEN) begin
        len_d = fs_new;
        if (tag_q == TAG_DATA) begin
          dfound_d = 1'b1;
          dstart_d = pos_q + POS_BITS'(1);
          dlen_d   = fs_new;
        end
        do_adv = !((tag_q == TAG_FMT) && (fs_new >= FMT_MIN_LEN));
      end else if (long_fmt) begin
        case (off)
          OFF_FORMAT:   fmt_format_d   = fs_new[31:16];
          OFF_CHANNELS: fmt_channels_d = fs_new[31:16];
          OFF_RATE:     fmt_rate_d     = fs_new;
          OFF_BITS: begin
            fmt_ok_d = (fmt_format_q == FORMAT_PCM)
                    && (fmt_channels_q == 16'(cfg_i.channels))
                    && (fmt_rate_q == 32'(cfg_i.rate))
                    && (fs_new[31:16] == 16'(cfg_i.bits));
            do_adv   = 1'b1;
          end
          default: ;
        endcase
      end
    end

    cs_d  = do_adv ? adv_cs : cs_q;
    pos_d = parse_en ? pos_q + POS_BITS'(1) : pos_q;

    // Snapshot for the result stage.
    fin_d.size        = parse_en ? pos_q + POS_BITS'(1) : POS_MAX;
    fin_d.magic_ok    = magic_d;
    fin_d.fmt_ok      = fmt_ok_d;
    fin_d.data_found  = dfound_d;
    fin_d.data_start  = dstart_d;
    fin_d.data_length = dlen_d;

    // The last byte of a file returns the walker to its start state.
    if (a_last_q) begin
      pos_d          = '0;
      cs_d           = CHUNK_FIRST;
      tag_d          = '0;
      len_d          = '0;
      fs_d           = '0;
      fmt_format_d   = '0;
      fmt_channels_d = '0;
      fmt_rate_d     = '0;
      magic_d        = 1'b0;
      fmt_ok_d       = 1'b0;
      dfound_d       = 1'b0;
      dstart_d       = '0;
      dlen_d         = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_byte_q <= in_byte_i;
      a_last_q <= in_last_i;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      cs_q           <= CHUNK_FIRST;
      tag_q          <= '0;
      len_q          <= '0;
      fs_q           <= '0;
      fmt_format_q   <= '0;
      fmt_channels_q <= '0;
      fmt_rate_q     <= '0;
      magic_q        <= 1'b0;
      fmt_ok_q       <= 1'b0;
      dfound_q       <= 1'b0;
      dstart_q       <= '0;
      dlen_q         <= '0;
    end else if (take) begin
      pos_q          <= pos_d;
      cs_q           <= cs_d;
      tag_q          <= tag_d;
      len_q          <= len_d;
      fs_q           <= fs_d;
      fmt_format_q   <= fmt_format_d;
      fmt_channels_q <= fmt_channels_d;
      fmt_rate_q     <= fmt_rate_d;
      magic_q        <= magic_d;
      fmt_ok_q       <= fmt_ok_d;
      dfound_q       <= dfound_d;
      dstart_q       <= dstart_d;
      dlen_q         <= dlen_d;
    end
  end

  // Capture stage toward the result logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (take && a_last_q) begin
      fin_valid_q <= 1'b1;
    end else if (fin_ready_i) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && a_last_q) begin
      fin_q <= fin_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

// ===== design/wavhp_result.sv =====
// Status decision, data length clamp and the output register.
module wavhp_result import wavhp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fin_valid_i,
  input  fin_t                fin_i,
  output logic                fin_ready_o,
  output logic                out_valid_o,
  output logic [2:0]          status_o,
  output logic [POS_BITS-1:0] data_offset_o,
  output logic [30:0]         frame_count_o,
  input  logic                out_ready_i
);

  logic                out_valid_q;
  logic [2:0]          status_q, status_d;
  logic [POS_BITS-1:0] offset_q, offset_d;
  logic [30:0]         frames_q, frames_d;

  logic                out_free;
  logic [POS_BITS-1:0] avail;
  logic [CMP_BITS-1:0] len_c;
  logic [30:0]         frames_c;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_ready_o = out_free;

  // Clamp the data length to what the file really holds.
  assign avail    = (fin_i.size >= fin_i.data_start) ? fin_i.size - fin_i.data_start : '0;
  assign len_c    = (CMP_BITS'(fin_i.data_length) > CMP_BITS'(avail))
                  ? CMP_BITS'(avail) : CMP_BITS'(fin_i.data_length);
  assign frames_c = len_c[31:1];

  // Checks in order of precedence.
  always_comb begin
    status_d = ST_OK;
    offset_d = '0;
    frames_d = '0;
    if (fin_i.size < MIN_SIZE) begin
      status_d = ST_SHORT;
    end else if (!fin_i.magic_ok) begin
      status_d = ST_BAD_TAG;
    end else if (!fin_i.fmt_ok) begin
      status_d = ST_BAD_FMT;
    end else if (!fin_i.data_found || (frames_c == '0)) begin
      status_d = ST_NO_DATA;
    end else begin
      offset_d = fin_i.data_start;
      frames_d = frames_c;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fin_valid_i) begin
      status_q <= status_d;
      offset_q <= offset_d;
      frames_q <= frames_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_offset_o = offset_q;
  assign frame_count_o = frames_q;

endmodule

// ===== design/wav_header_chunk_parser_core.sv =====
// Top level of the RIFF/WAVE header parser.
//
// The file arrives on in_i one byte per beat, with last_byte set on its final
// byte. Each byte goes through an input register and then updates the chunk
// walker: tag checks at offsets 0 and 8, chunk headers from offset 12, and
// the fields of the fmt and data chunks. Only the beat that carries
// last_byte produces a result on out_o: status, data offset and frame count.
// Throughput is one byte per cycle while in_i ready stays high; the walker
// updates on every byte taken. A result passes from the input register through
// the capture register to the output register, whose contents drive out_o.
// When out_o stalls, a finished result waits in the output register and one
// more in the capture register; bytes that are not last keep flowing, and
// in_i ready drops only when a last byte finds both registers full.
// Reset clears the parser and sets the expected rate, channels and bits to
// 48000, 1 and 16. The user must write them through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle, which the block does not enforce;
// an unused index is ignored. After a last byte the parser restarts at offset 0.
module wav_header_chunk_parser_core import wavhp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  wavhp_in_if.sink             in_i,
  wavhp_out_if.source          out_o
);

  cfg_t cfg_q;
  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate     <= RATE_RESET;
      cfg_q.channels <= CHANNELS_RESET;
      cfg_q.bits     <= BITS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RATE:     cfg_q.rate     <= cfg_data_i[RATE_W-1:0];
        CFG_CHANNELS: cfg_q.channels <= cfg_data_i[CH_W-1:0];
        CFG_BITS:     cfg_q.bits     <= cfg_data_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  wavhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.byte_value),
    .in_last_i   (in_i.last_byte),
    .in_ready_o  (in_i.ready),
    .fin_valid_o (fin_valid),
    .fin_o       (fin),
    .fin_ready_i (fin_ready)
  );

  wavhp_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_valid_i   (fin_valid),
    .fin_i         (fin),
    .fin_ready_o   (fin_ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .data_offset_o (out_o.data_offset),
    .frame_count_o (out_o.frame_count),
    .out_ready_i   (out_o.ready)
  );

endmodule
